>>> rtl/plds_pkg.sv
// Shared package of the polyline distance substring block.
// Holds default widths, register indexes, point kinds and the arithmetic unit handshake types.
// No dependencies.
`default_nettype none
package plds_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int DIST_BITS_DEF  = 48;
	localparam int CFG_IDX_BITS   = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_START_DIST = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_END_DIST   = 2'd1;

	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_VERTEX = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	typedef enum logic [1:0] {
		OP_LEN    = 2'b01,
		OP_INTERP = 2'b10
	} plds_op_t;

	typedef struct packed {
		logic     start;
		plds_op_t op;
	} plds_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} plds_status_t;

endpackage
`default_nettype wire

>>> rtl/plds_front.sv
// Front end: accepts vertices, flags the first vertex of each polyline and
// forms the coordinate deltas against the previous vertex. Uses plds_pkg.
`default_nettype none
module plds_front import plds_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [COORD_BITS-1:0]     vertex_x,
	input  logic [COORD_BITS-1:0]     vertex_y,
	input  logic                      final_vertex,
	output logic                      push_valid,
	input  logic                      push_ready,
	output logic [4*COORD_BITS+3:0]   push_data
);

	logic                  v_s1;
	logic [COORD_BITS-1:0] x_s1, y_s1;
	logic                  fin_s1, first_s1;
	logic [COORD_BITS:0]   dx_s1, dy_s1;
	logic [COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic                  first_q;
	logic                  accept;

	assign in_ready   = !v_s1 || push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = v_s1;
	assign push_data  = {x_s1, y_s1, fin_s1, first_s1, dx_s1, dy_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			first_q <= 1'b1;
		end else begin
			v_s1 <= accept || (v_s1 && !push_ready);
			// The polyline after a final vertex starts fresh.
			if (accept) begin
				first_q <= final_vertex;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1     <= vertex_x;
			y_s1     <= vertex_y;
			fin_s1   <= final_vertex;
			first_s1 <= first_q;
			dx_s1    <= {vertex_x[COORD_BITS-1], vertex_x} - {prev_x_q[COORD_BITS-1], prev_x_q};
			dy_s1    <= {vertex_y[COORD_BITS-1], vertex_y} - {prev_y_q[COORD_BITS-1], prev_y_q};
			prev_x_q <= vertex_x;
			prev_y_q <= vertex_y;
		end
	end

endmodule
`default_nettype wire

>>> rtl/plds_queue.sv
// Two-entry queue between the front end and the back end.
// Generic width; no package dependencies.
`default_nettype none
module plds_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             do_push, do_pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

>>> rtl/plds_arith.sv
// Shared iterative arithmetic unit: segment length (two squares and a bitwise
// square root) and saturated scaled quotient (shift-add product, restoring divide). Uses plds_pkg.
`default_nettype none
module plds_arith import plds_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int DIST_BITS  = DIST_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  plds_req_t             req,
	input  logic [COORD_BITS:0]   opa,
	input  logic [COORD_BITS:0]   opb,
	input  logic [DIST_BITS-1:0]  span,
	input  logic [DIST_BITS-1:0]  divisor,
	output plds_status_t          status,
	output logic [COORD_BITS:0]   result
);

	localparam int MW   = COORD_BITS + 1;
	localparam int SW   = 2 * MW;
	localparam int DW   = DIST_BITS;
	localparam int PW   = MW + DW;
	localparam int CNTW = $clog2(MW + 1);
	localparam logic [MW-1:0] CAP = {1'b1, {COORD_BITS{1'b0}}};

	typedef enum logic [6:0] {
		A_IDLE = 7'b0000001,
		A_SQX  = 7'b0000010,
		A_SQY  = 7'b0000100,
		A_ROOT = 7'b0001000,
		A_MUL  = 7'b0010000,
		A_CHK  = 7'b0100000,
		A_DIV  = 7'b1000000
	} astate_t;

	astate_t         state_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [MW-1:0]   a_q, b_q, root_q;
	logic [SW-1:0]   sq_q, prod;
	logic [PW-1:0]   acc_q;
	logic [DW-1:0]   m_q, den_q, drem_q;
	logic [MW+1:0]   srem_q;
	logic [MW+2:0]   r_next, trial;
	logic [DW:0]     r2;
	logic            r2_ge;
	logic [MW-1:0]   q_next;

	assign prod   = (state_q == A_SQX) ? a_q * a_q : b_q * b_q;
	assign r_next = {srem_q[MW:0], sq_q[SW-1:SW-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign r2     = {drem_q, acc_q[MW-1]};
	assign r2_ge  = r2 >= {1'b0, den_q};
	assign q_next = {root_q[MW-2:0], r2_ge};

	assign status.busy = state_q != A_IDLE;
	assign status.done = done_q;
	assign result      = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						cnt_q   <= CNTW'(MW);
						state_q <= (req.op == OP_LEN) ? A_SQX : A_MUL;
					end
				end
				A_SQX: state_q <= A_SQY;
				A_SQY: state_q <= A_ROOT;
				A_ROOT, A_MUL, A_DIV: begin
					cnt_q <= cnt_q - CNTW'(1);
					if (cnt_q == CNTW'(1)) begin
						if (state_q == A_MUL) begin
							state_q <= A_CHK;
						end else begin
							state_q <= A_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				A_CHK: begin
					cnt_q <= CNTW'(MW);
					// A quotient that cannot fit skips the divide entirely.
					if (acc_q[PW-1:MW] >= den_q) begin
						state_q <= A_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= A_DIV;
					end
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				a_q    <= opa;
				b_q    <= opb;
				m_q    <= span;
				den_q  <= divisor;
				acc_q  <= '0;
				root_q <= '0;
				srem_q <= '0;
			end
			A_SQX: sq_q <= prod;
			A_SQY: sq_q <= sq_q + prod;
			A_ROOT: begin
				sq_q <= {sq_q[SW-3:0], 2'b00};
				if (r_next >= trial) begin
					srem_q <= (MW+2)'(r_next - trial);
					root_q <= {root_q[MW-2:0], 1'b1};
				end else begin
					srem_q <= r_next[MW+1:0];
					root_q <= {root_q[MW-2:0], 1'b0};
				end
			end
			A_MUL: begin
				acc_q <= {acc_q[PW-2:0], 1'b0} + (a_q[MW-1] ? PW'(m_q) : PW'(0));
				a_q   <= {a_q[MW-2:0], 1'b0};
			end
			A_CHK: begin
				drem_q <= acc_q[PW-1:MW];
				if (acc_q[PW-1:MW] >= den_q) begin
					root_q <= CAP;
				end
			end
			A_DIV: begin
				acc_q  <= {acc_q[PW-2:0], 1'b0};
				drem_q <= r2_ge ? DW'(r2 - {1'b0, den_q}) : r2[DW-1:0];
				if (cnt_q == CNTW'(1) && q_next[MW-1]) begin
					root_q <= CAP;
				end else begin
					root_q <= q_next;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/plds_back.sv
// Back end: sequences one vertex at a time through the phase logic, drives the
// shared arithmetic unit and holds the result output register. Uses plds_pkg.
`default_nettype none
module plds_back import plds_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int DIST_BITS  = DIST_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	output logic                      q_pop,
	input  logic [4*COORD_BITS+3:0]   q_data,
	input  logic [DIST_BITS-1:0]      start_dist,
	input  logic [DIST_BITS-1:0]      end_dist,
	output plds_req_t                 req,
	input  plds_status_t              status,
	output logic [COORD_BITS:0]       opa,
	output logic [COORD_BITS:0]       opb,
	output logic [DIST_BITS-1:0]      span,
	output logic [DIST_BITS-1:0]      divisor,
	input  logic [COORD_BITS:0]       result,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [COORD_BITS-1:0]     point_x,
	output logic [COORD_BITS-1:0]     point_y,
	output logic [1:0]                point_kind,
	output logic                      last_point
);

	localparam int CW   = COORD_BITS;
	localparam int DW   = DIST_BITS;
	localparam int SUMW = ((DW > CW + 1) ? DW : CW + 1) + 1;
	localparam logic [DW-1:0] DIST_MAX = '1;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_SEEK   = 4'b0010,
		PH_INSIDE = 4'b0100,
		PH_DRAIN  = 4'b1000
	} phase_t;

	typedef enum logic [10:0] {
		ST_WAIT   = 11'b00000000001,
		ST_CLASS  = 11'b00000000010,
		ST_LEN    = 11'b00000000100,
		ST_DECIDE = 11'b00000001000,
		ST_TAIL   = 11'b00000010000,
		ST_IX     = 11'b00000100000,
		ST_IXW    = 11'b00001000000,
		ST_IY     = 11'b00010000000,
		ST_IYW    = 11'b00100000000,
		ST_PUT    = 11'b01000000000,
		ST_EMIT   = 11'b10000000000
	} bstate_t;

	phase_t        phase_q;
	bstate_t       st_q, nxt_q;
	logic          goal_end_q;
	logic [CW-1:0] e_x_q, e_y_q;
	logic          e_fin_q;
	logic [CW:0]   e_dx_q, e_dy_q;
	logic [CW-1:0] ox_q, oy_q, ex_q, ey_q, emx_q, emy_q;
	logic [DW-1:0] lb_q, la_q;
	logic [CW-1:0] px_q, py_q;
	logic [1:0]    pk_q;
	logic          pl_q;

	logic [CW:0]     mag_dx, mag_dy, d_cur;
	logic [DW-1:0]   t_dist;
	logic            t_lt, neg, len_zero, out_load;
	logic [CW-1:0]   o_cur, clamped;
	logic [CW+1:0]   r_sum;
	logic [SUMW-1:0] la_sum;
	logic [DW-1:0]   la_new;

	assign mag_dx   = e_dx_q[CW] ? (CW+1)'(0) - e_dx_q : e_dx_q;
	assign mag_dy   = e_dy_q[CW] ? (CW+1)'(0) - e_dy_q : e_dy_q;
	assign t_dist   = goal_end_q ? end_dist : start_dist;
	assign t_lt     = t_dist < lb_q;
	assign len_zero = la_q == lb_q;
	assign d_cur    = (st_q == ST_IY || st_q == ST_IYW) ? e_dy_q : e_dx_q;
	assign o_cur    = (st_q == ST_IY || st_q == ST_IYW) ? oy_q : ox_q;
	assign neg      = d_cur[CW] ^ t_lt;

	assign opa     = (st_q == ST_IY) ? mag_dy : mag_dx;
	assign opb     = mag_dy;
	assign span    = t_lt ? lb_q - t_dist : t_dist - lb_q;
	assign divisor = la_q - lb_q;

	assign req.start = st_q == ST_CLASS && (phase_q == PH_SEEK || phase_q == PH_INSIDE)
		|| (st_q == ST_IX || st_q == ST_IY) && !len_zero;
	assign req.op    = (st_q == ST_CLASS) ? OP_LEN : OP_INTERP;

	// Origin plus or minus the scaled offset, clamped to the coordinate range.
	assign r_sum = neg ? {{2{o_cur[CW-1]}}, o_cur} - {1'b0, result}
		: {{2{o_cur[CW-1]}}, o_cur} + {1'b0, result};
	always_comb begin
		if ($signed(r_sum) > $signed({3'b000, {(CW-1){1'b1}}})) begin
			clamped = {1'b0, {(CW-1){1'b1}}};
		end else if ($signed(r_sum) < $signed({3'b111, {(CW-1){1'b0}}})) begin
			clamped = {1'b1, {(CW-1){1'b0}}};
		end else begin
			clamped = r_sum[CW-1:0];
		end
	end

	assign la_sum = SUMW'(la_q) + SUMW'(result);
	assign la_new = (la_sum > SUMW'(DIST_MAX)) ? DIST_MAX : la_sum[DW-1:0];

	assign q_pop    = st_q == ST_WAIT && q_valid;
	assign out_load = st_q == ST_EMIT && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_WAIT;
			nxt_q      <= ST_WAIT;
			phase_q    <= PH_IDLE;
			goal_end_q <= 1'b0;
			out_valid  <= 1'b0;
			ox_q       <= '0;
			oy_q       <= '0;
			ex_q       <= '0;
			ey_q       <= '0;
			emx_q      <= '0;
			emy_q      <= '0;
			lb_q       <= '0;
			la_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (st_q)
				ST_WAIT: begin
					if (q_valid) begin
						st_q <= ST_CLASS;
					end
				end
				ST_CLASS: begin
					unique case (phase_q)
						PH_IDLE: begin
							ox_q <= e_x_q;
							ex_q <= e_x_q;
							oy_q <= e_y_q;
							ey_q <= e_y_q;
							lb_q <= '0;
							la_q <= '0;
							if (e_fin_q) begin
								emx_q <= e_x_q;
								emy_q <= e_y_q;
								nxt_q <= ST_WAIT;
								st_q  <= ST_EMIT;
							end else begin
								phase_q <= PH_SEEK;
								st_q    <= ST_WAIT;
							end
						end
						PH_DRAIN: begin
							if (e_fin_q) begin
								phase_q <= PH_IDLE;
							end
							st_q <= ST_WAIT;
						end
						default: st_q <= ST_LEN;
					endcase
				end
				ST_LEN: begin
					if (status.done) begin
						ox_q <= ex_q;
						oy_q <= ey_q;
						ex_q <= e_x_q;
						ey_q <= e_y_q;
						lb_q <= la_q;
						la_q <= la_new;
						st_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (phase_q == PH_SEEK) begin
						if (la_q < start_dist && !e_fin_q) begin
							st_q <= ST_WAIT;
						end else begin
							goal_end_q <= 1'b0;
							st_q       <= ST_IX;
						end
					end else begin
						st_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					if (!e_fin_q && la_q < end_dist) begin
						phase_q <= PH_INSIDE;
						// A vertex equal to the last emitted point is skipped.
						if (ex_q != emx_q || ey_q != emy_q) begin
							emx_q <= ex_q;
							emy_q <= ey_q;
							nxt_q <= ST_WAIT;
							st_q  <= ST_EMIT;
						end else begin
							st_q <= ST_WAIT;
						end
					end else if (start_dist != end_dist) begin
						goal_end_q <= 1'b1;
						st_q       <= ST_IX;
					end else begin
						phase_q <= e_fin_q ? PH_IDLE : PH_DRAIN;
						st_q    <= ST_WAIT;
					end
				end
				ST_IX: st_q <= len_zero ? ST_IY : ST_IXW;
				ST_IXW: begin
					if (status.done) begin
						st_q <= ST_IY;
					end
				end
				ST_IY: st_q <= len_zero ? ST_PUT : ST_IYW;
				ST_IYW: begin
					if (status.done) begin
						st_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (goal_end_q) begin
						phase_q <= e_fin_q ? PH_IDLE : PH_DRAIN;
						nxt_q   <= ST_WAIT;
					end else begin
						emx_q <= px_q;
						emy_q <= py_q;
						nxt_q <= ST_TAIL;
					end
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						st_q <= nxt_q;
					end
				end
				default: st_q <= ST_WAIT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			{e_x_q, e_y_q, e_fin_q} <= q_data[4*CW+3:2*CW+3];
			e_dx_q                  <= q_data[2*CW+1:CW+1];
			e_dy_q                  <= q_data[CW:0];
		end
		if (st_q == ST_CLASS) begin
			px_q <= e_x_q;
			py_q <= e_y_q;
			pk_q <= KIND_VERTEX;
			pl_q <= 1'b1;
		end
		if (st_q == ST_TAIL) begin
			px_q <= ex_q;
			py_q <= ey_q;
			pk_q <= KIND_VERTEX;
			pl_q <= 1'b0;
		end
		if (st_q == ST_IX) begin
			px_q <= ox_q;
		end
		if (st_q == ST_IXW && status.done) begin
			px_q <= clamped;
		end
		if (st_q == ST_IY) begin
			py_q <= oy_q;
		end
		if (st_q == ST_IYW && status.done) begin
			py_q <= clamped;
		end
		if (st_q == ST_PUT) begin
			pk_q <= goal_end_q ? KIND_END : KIND_START;
			pl_q <= goal_end_q || start_dist == end_dist;
		end
		if (out_load) begin
			point_x    <= px_q;
			point_y    <= py_q;
			point_kind <= pk_q;
			last_point <= pl_q;
		end
	end

`ifndef SYNTHESIS
	a_first_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_data[2*CW+2] == (phase_q == PH_IDLE)))
		else $error("first-vertex flag disagrees with phase");
	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !status.busy)
		else $error("arithmetic unit started while busy");
	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> (st_q == ST_LEN || st_q == ST_IXW || st_q == ST_IYW))
		else $error("arithmetic result arrived in an unexpected state");
`endif

endmodule
`default_nettype wire

>>> rtl/polyline_distance_substring.sv
// The point of a one-vertex polyline passes the front register, the queue, the back end's
// class and emit states and the output register; a vertex that advances the line waits on a
// square root before its point; each interpolated point adds two products and two divides,
// one bit per cycle in one shared unit.
// Throughput: one vertex at a time in the back end; the front end and a two-entry queue
// keep taking vertices meanwhile until they fill. Reset (arst_n low) clears all control state at once.
`default_nettype none
module polyline_distance_substring import plds_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int DIST_BITS  = DIST_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DIST_BITS-1:0]    cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [COORD_BITS-1:0]   vertex_x,
	input  logic [COORD_BITS-1:0]   vertex_y,
	input  logic                    final_vertex,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [COORD_BITS-1:0]   point_x,
	output logic [COORD_BITS-1:0]   point_y,
	output logic [1:0]              point_kind,
	output logic                    last_point
);

	localparam int EW = 4 * COORD_BITS + 4;

	logic [DIST_BITS-1:0] start_q, end_q;
	logic                 push_valid, push_ready, q_valid, q_pop;
	logic [EW-1:0]        push_data, q_data;
	plds_req_t            req;
	plds_status_t         status;
	logic [COORD_BITS:0]  opa, opb, result;
	logic [DIST_BITS-1:0] span, divisor;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START_DIST: start_q <= cfg_data;
				REG_END_DIST:   end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	plds_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .vertex_x, .vertex_y, .final_vertex,
		.push_valid, .push_ready, .push_data
	);

	plds_queue #(.WIDTH(EW)) u_queue (
		.clk, .arst_n, .push_valid, .push_ready, .push_data,
		.pop_valid(q_valid), .pop(q_pop), .pop_data(q_data)
	);

	plds_arith #(.COORD_BITS(COORD_BITS), .DIST_BITS(DIST_BITS)) u_arith (
		.clk, .arst_n, .req, .opa, .opb, .span, .divisor, .status, .result
	);

	plds_back #(.COORD_BITS(COORD_BITS), .DIST_BITS(DIST_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_data,
		.start_dist(start_q), .end_dist(end_q),
		.req, .status, .opa, .opb, .span, .divisor, .result,
		.out_valid, .out_ready, .point_x, .point_y, .point_kind, .last_point
	);

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Testbench for polyline_distance_substring: random and directed polylines under several
// distance windows, checked against a substring predictor kept in a scoreboard class.
// Depends on rtl/plds_pkg.sv and rtl/polyline_distance_substring.sv.
`timescale 1ns / 1ps

module tb_top;
	import plds_pkg::*;

	localparam logic [47:0] DIST_TOP = 48'hFFFF_FFFF_FFFF;
	localparam int WATCH_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 400;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [1:0]  kind;
		logic        last;
	} point_t;

	class substring_board;
		typedef enum logic [1:0] {AWAIT_FIRST, SEEKING, INSIDE, DRAINING} walk_t;
		point_t      want_q[$];
		int          errors;
		logic [47:0] start_d, end_d, len_org, len_end;
		longint      org_x, org_y, end_x, end_y, emit_x, emit_y;
		walk_t       walk;

		function void clear();
			start_d = 0; end_d = 0; len_org = 0; len_end = 0;
			org_x = 0; org_y = 0; end_x = 0; end_y = 0; emit_x = 0; emit_y = 0;
			walk = AWAIT_FIRST;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [47:0] val);
			if (idx == REG_START_DIST) start_d = val;
			else if (idx == REG_END_DIST) end_d = val;
		endfunction

		function logic [63:0] magnitude(longint v);
			return v < 0 ? -v : v;
		endfunction

		function longint lerp(longint o, longint d, logic [47:0] t);
			logic [47:0]  span;
			logic [63:0]  m;
			logic [127:0] prod, q;
			longint       r;
			span = len_end - len_org;
			if (span == 0) return o;
			m = (t >= len_org) ? t - len_org : len_org - t;
			prod = 128'(magnitude(d)) * 128'(m);
			q = prod / 128'(span);
			if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
			r = ((d < 0) != (t < len_org)) ? o - longint'(q) : o + longint'(q);
			if (r > 64'sd2147483647) r = 64'sd2147483647;
			if (r < -64'sd2147483648) r = -64'sd2147483648;
			return r;
		endfunction

		function void push(longint x, longint y, logic [1:0] kind, logic last);
			point_t p;
			p.x = x[31:0]; p.y = y[31:0]; p.kind = kind; p.last = last;
			want_q.push_back(p);
		endfunction

		function void extend(longint x, longint y);
			logic [127:0] sq, c2;
			logic [63:0]  root, c;
			sq = 128'(magnitude(x - end_x)) * 128'(magnitude(x - end_x))
				+ 128'(magnitude(y - end_y)) * 128'(magnitude(y - end_y));
			root = 0;
			for (int b = 63; b >= 0; b--) begin
				c = root | (64'd1 << b);
				c2 = 128'(c) * 128'(c);
				if (c2 <= sq) root = c;
			end
			org_x = end_x; org_y = end_y; end_x = x; end_y = y;
			len_org = len_end;
			if (root > 64'(DIST_TOP - len_end)) len_end = DIST_TOP;
			else len_end = len_end + root[47:0];
		endfunction

		// Emit a new end vertex while inside the window, else the end point unless start and end are equal.
		function void finish_segment(bit fin);
			if (!fin && len_end < end_d) begin
				if (end_x != emit_x || end_y != emit_y) begin
					push(end_x, end_y, KIND_VERTEX, 1'b0);
					emit_x = end_x; emit_y = end_y;
				end
				walk = INSIDE;
				return;
			end
			if (start_d != end_d)
				push(lerp(org_x, end_x - org_x, end_d), lerp(org_y, end_y - org_y, end_d),
					KIND_END, 1'b1);
			walk = fin ? AWAIT_FIRST : DRAINING;
		endfunction

		function void note_vertex(logic [31:0] vx, logic [31:0] vy, logic fin);
			longint x, y, px, py;
			x = longint'(signed'(vx));
			y = longint'(signed'(vy));
			case (walk)
				AWAIT_FIRST: begin
					org_x = x; end_x = x; org_y = y; end_y = y;
					len_org = 0; len_end = 0;
					if (fin) begin
						push(x, y, KIND_VERTEX, 1'b1);
						emit_x = x; emit_y = y;
					end else walk = SEEKING;
				end
				SEEKING: begin
					extend(x, y);
					if (len_end >= start_d || fin) begin
						px = lerp(org_x, end_x - org_x, start_d);
						py = lerp(org_y, end_y - org_y, start_d);
						push(px, py, KIND_START, start_d == end_d);
						emit_x = px; emit_y = py;
						finish_segment(fin);
					end
				end
				INSIDE: begin
					extend(x, y);
					finish_segment(fin);
				end
				default: if (fin) walk = AWAIT_FIRST;
			endcase
		endfunction

		function void check_point(point_t got);
			point_t w;
			if (want_q.size() == 0) begin
				$display("%0t: unexpected point x=%h y=%h kind=%0d last=%0b", $time,
					got.x, got.y, got.kind, got.last);
				errors++;
				return;
			end
			w = want_q.pop_front();
			if (got.x !== w.x) begin
				$display("%0t: point_x expected %h actual %h", $time, w.x, got.x); errors++;
			end
			if (got.y !== w.y) begin
				$display("%0t: point_y expected %h actual %h", $time, w.y, got.y); errors++;
			end
			if (got.kind !== w.kind) begin
				$display("%0t: point_kind expected %0d actual %0d", $time, w.kind, got.kind);
				errors++;
			end
			if (got.last !== w.last) begin
				$display("%0t: last_point expected %0b actual %0b", $time, w.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0, cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;
	logic        in_valid = 1'b0, in_ready;
	logic [31:0] vertex_x = '0, vertex_y = '0;
	logic        final_vertex = 1'b0;
	logic        out_valid, out_ready = 1'b0;
	logic [31:0] point_x, point_y;
	logic [1:0]  point_kind;
	logic        last_point;

	substring_board sb;
	bit  quiet;
	int  sent;
	int  idle_cycles;
	longint cur_x, cur_y;

	always #5 clk = ~clk;

	polyline_distance_substring dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .vertex_x(vertex_x), .vertex_y(vertex_y),
		.final_vertex(final_vertex),
		.out_valid(out_valid), .out_ready(out_ready), .point_x(point_x), .point_y(point_y),
		.point_kind(point_kind), .last_point(last_point)
	);

	// Input transfers are recorded before output transfers of the same edge.
	always @(posedge clk) begin
		point_t p;
		if (arst_n && in_valid && in_ready)
			sb.note_vertex(vertex_x, vertex_y, final_vertex);
		if (arst_n && out_valid && out_ready) begin
			p.x = point_x; p.y = point_y; p.kind = point_kind; p.last = last_point;
			sb.check_point(p);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCH_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	function automatic logic [47:0] rand48();
		return {$urandom, $urandom};
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [47:0] val);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_vertex(longint x, longint y, bit fin);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1; vertex_x <= x[31:0]; vertex_y <= y[31:0]; final_vertex <= fin;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid <= 1'b0;
		sent++;
	endtask

	// Waits out every expected point plus the time a point-less vertex may still need.
	task automatic settle();
		while (sb.want_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_window(logic [47:0] s, logic [47:0] e);
		settle();
		write_reg(REG_START_DIST, s);
		write_reg(REG_END_DIST, e);
	endtask

	// One random polyline; steps are bounded by 2**scale unless a full-range jump is drawn.
	task automatic random_polyline(int scale);
		int nv;
		longint step;
		nv = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 9);
		cur_x = longint'(signed'(32'($urandom)));
		cur_y = longint'(signed'(32'($urandom)));
		for (int i = 0; i < nv; i++) begin
			if (i > 0) begin
				case ($urandom_range(0, 19))
					0, 1, 2: ;
					3: begin
						cur_x = longint'(signed'(32'($urandom)));
						cur_y = longint'(signed'(32'($urandom)));
					end
					default: begin
						step = longint'(1) << scale;
						cur_x = cur_x + longint'($urandom_range(0, 1 << 30)) % (2 * step + 1) - step;
						cur_y = cur_y + longint'($urandom_range(0, 1 << 30)) % (2 * step + 1) - step;
					end
				endcase
				cur_x = longint'(signed'(cur_x[31:0]));
				cur_y = longint'(signed'(cur_y[31:0]));
			end
			send_vertex(cur_x, cur_y, i == nv - 1);
		end
	endtask

	initial begin
		int scale, target;
		logic [47:0] span, s, e;
		sb = new;
		sb.clear();
		quiet = 1'b0;
		sent = 0;
		idle_cycles = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Equal zero window: a lone vertex, then lines that give a start point only, one with a zero-length segment.
		send_vertex(5, 7, 1);
		send_vertex(100, 100, 0);
		send_vertex(100, 100, 0);
		send_vertex(900, 100, 1);
		send_vertex(-64'sd2147483648, 64'sd2147483647, 0);
		send_vertex(64'sd2147483647, -64'sd2147483648, 1);

		// A window inside the line, with a repeated vertex and vertices past the end.
		set_window(48'd1 << 16, 48'd10 << 16);
		send_vertex(0, 0, 0);
		send_vertex(5 << 16, 0, 0);
		send_vertex(5 << 16, 0, 0);
		send_vertex(5 << 16, 3 << 16, 0);
		send_vertex(20 << 16, 0, 0);
		send_vertex(30 << 16, 0, 0);
		send_vertex(40 << 16, 0, 1);

		// Window beyond the line: extrapolation along the last segment saturates.
		set_window(DIST_TOP, DIST_TOP);
		write_reg(2'd2, 48'd0);
		write_reg(2'd3, 48'd0);
		send_vertex(-64'sd2147483648, -64'sd2147483648, 0);
		send_vertex(64'sd2147483647, 64'sd2147483647, 0);
		send_vertex(0, 1, 1);

		// Whole line: start point at the first vertex, inner vertices (a repeat skipped), end point past the final segment.
		set_window(0, DIST_TOP);
		send_vertex(0, 0, 0);
		send_vertex(0, 0, 0);
		send_vertex(64'sd2147483647, 0, 0);
		send_vertex(-64'sd2147483648, 64'sd2147483647, 1);

		// End before start.
		set_window(48'd50 << 16, 48'd2 << 16);
		send_vertex(0, 0, 0);
		send_vertex(100 << 16, 0, 1);

		target = sent;
		for (int ph = 0; ph < 14; ph++) begin
			scale = $urandom_range(4, 26);
			span = 48'd6 << scale;
			case (ph % 5)
				0: begin s = rand48() % (span + 1); e = s + rand48() % (span + 1); end
				1: begin s = rand48() % (span + 1); e = s; end
				2: begin s = 0; e = rand48() % (span + 1); end
				3: begin s = rand48(); e = rand48(); end
				default: begin s = rand48() % (span + 1); e = rand48() % (span + 1); end
			endcase
			set_window(s, e);
			quiet = ($urandom_range(0, 3) == 0);
			target += 95;
			while (sent < target) random_polyline(scale);
		end

		quiet = 1'b0;
		settle();
		if (sb.want_q.size() != 0) begin
			$display("%0t: %0d expected points never arrived", $time, sb.want_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
